### sv/vrgb_pkg.sv
package vrgb_pkg;

   localparam int CFG_W       = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int COLOR_W     = 8;
   localparam int HUE_W       = 9;
   localparam int FRAC_W      = 6;
   localparam int XQ_W        = 14;
   localparam int PN_W        = 16;
   localparam int QN_W        = 22;

   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_MIN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_MAX  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SATURATION = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS = 2'd3;

   localparam logic signed [CFG_W-1:0] RANGE_MIN_RST  = -32'sd300000;
   localparam logic signed [CFG_W-1:0] RANGE_MAX_RST  = -32'sd150000;
   localparam logic [COLOR_W-1:0]      SATURATION_RST = 8'd230;
   localparam logic [COLOR_W-1:0]      BRIGHTNESS_RST = 8'd230;

   localparam logic [COLOR_W-1:0] COLOR_FULL   = 8'd255;
   localparam logic [FRAC_W-1:0]  SECTOR_WIDTH = 6'd60;
   localparam logic [XQ_W-1:0]    FRAC_SCALE   = 14'd15300;

   // Floor division by 255 and by 15300 as a multiply by a rounded-up reciprocal.
   localparam int P_SHIFT = 24;
   localparam int Q_SHIFT = 36;
   localparam int P_RECIP_W = 17;
   localparam int Q_RECIP_W = 23;
   localparam logic [P_RECIP_W-1:0] P_RECIP =
      17'(((64'd1 << P_SHIFT) + 64'd254) / 64'd255);
   localparam logic [Q_RECIP_W-1:0] Q_RECIP =
      23'(((64'd1 << Q_SHIFT) + 64'd15299) / 64'd15300);

   typedef enum logic [2:0] {
      SEC_RED_YELLOW,
      SEC_YELLOW_GREEN,
      SEC_GREEN_CYAN,
      SEC_CYAN_BLUE,
      SEC_BLUE_MAGENTA,
      SEC_MAGENTA_RED
   } sector_type;

endpackage

### sv/vrgb_front.sv
module vrgb_front
   import vrgb_pkg::*;
#(
   parameter int SAMPLE_BITS = 32,
   parameter int HUE_SPAN    = 240
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   input  logic signed [CFG_W-1:0]       range_min,
   input  logic signed [CFG_W-1:0]       range_max,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [CFG_W+$clog2(HUE_SPAN+1)-1:0] out_num,
   output logic [CFG_W-1:0]              out_den
);

   localparam int QB = $clog2(HUE_SPAN + 1);
   localparam int NW = CFG_W + QB;
   localparam int SW = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

   logic                 a_valid_ff, a_valid_in;
   logic                 b_valid_ff, b_valid_in;
   logic                 a_ready, b_ready;
   logic [CFG_W-1:0]     diff_ff, diff_in;
   logic [CFG_W-1:0]     den_a_ff, den_a_in;
   logic [NW-1:0]        num_ff, num_in;
   logic [CFG_W-1:0]     den_b_ff;
   logic signed [SW-1:0] sample_x, min_x, max_x, clamped;
   logic                 window_ok;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      sample_x  = SW'(in_sample);
      min_x     = SW'(range_min);
      max_x     = SW'(range_max);
      window_ok = range_max > range_min;
      if (sample_x < min_x) begin
         clamped = min_x;
      end else if (sample_x > max_x) begin
         clamped = max_x;
      end else begin
         clamped = sample_x;
      end
      if (window_ok) begin
         diff_in  = clamped[CFG_W-1:0] - range_min;
         den_a_in = range_max - range_min;
      end else begin
         diff_in  = '0;
         den_a_in = CFG_W'(1);
      end
      num_in     = NW'(diff_ff) * NW'(HUE_SPAN);
      a_valid_in = a_ready ? in_valid : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      if (a_ready && in_valid) begin
         diff_ff  <= diff_in;
         den_a_ff <= den_a_in;
      end
      if (b_ready && a_valid_ff) begin
         num_ff   <= num_in;
         den_b_ff <= den_a_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_b_ff;

endmodule

### sv/vrgb_div_cell.sv
module vrgb_div_cell
   import vrgb_pkg::*;
#(
   parameter int NW  = 40,
   parameter int QB  = 8,
   parameter int BIT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [NW-1:0]    in_rem,
   input  logic [CFG_W-1:0] in_den,
   input  logic [QB-1:0]    in_quo,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [NW-1:0]    out_rem,
   output logic [CFG_W-1:0] out_den,
   output logic [QB-1:0]    out_quo
);

   logic             valid_ff, valid_in;
   logic [NW-1:0]    rem_ff, rem_in;
   logic [CFG_W-1:0] den_ff;
   logic [QB-1:0]    quo_ff, quo_in;
   logic [NW-1:0]    shifted;
   logic             fits;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shifted  = NW'(in_den) << BIT;
      fits     = in_rem >= shifted;
      rem_in   = fits ? (in_rem - shifted) : in_rem;
      quo_in   = in_quo | (QB'(fits) << BIT);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         rem_ff <= rem_in;
         den_ff <= in_den;
         quo_ff <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;

endmodule

### sv/vrgb_color.sv
module vrgb_color
   import vrgb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [HUE_W-1:0]   in_hue,
   input  logic [COLOR_W-1:0] saturation,
   input  logic [COLOR_W-1:0] brightness,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [COLOR_W-1:0] out_hue,
   output logic [COLOR_W-1:0] out_red,
   output logic [COLOR_W-1:0] out_green,
   output logic [COLOR_W-1:0] out_blue
);

   localparam int PP_W = PN_W + P_RECIP_W;
   localparam int QP_W = QN_W + Q_RECIP_W;

   logic [4:0] valid_ff, valid_in, ready;

   logic [HUE_W-1:0]   hue1_ff, hue2_ff, hue3_ff, hue4_ff, hue5_ff;
   sector_type         sec1_ff, sec2_ff, sec3_ff, sec4_ff, sec_in;
   logic [FRAC_W-1:0]  f1_ff, f_in;
   logic [HUE_W-1:0]   base;
   logic [COLOR_W-1:0] xp2_ff, xp_in;
   logic [XQ_W-1:0]    xq2_ff, xq_in, xt2_ff, xt_in;
   logic [PN_W-1:0]    pn3_ff, pn_in;
   logic [QN_W-1:0]    qn3_ff, qn_in, tn3_ff, tn_in;
   logic [PP_W-1:0]    p_prod;
   logic [QP_W-1:0]    q_prod, t_prod;
   logic [COLOR_W-1:0] p4_ff, p_in, q4_ff, q_in, t4_ff, t_in;
   logic [COLOR_W-1:0] red5_ff, red_in, green5_ff, green_in, blue5_ff, blue_in;

   always_comb begin
      ready[4] = !valid_ff[4] || out_ready;
      for (int i = 3; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in[0] = ready[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < 5; i++) begin
         valid_in[i] = ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   assign in_ready = ready[0];

   always_comb begin
      if (in_hue >= 9'd300) begin
         sec_in = SEC_MAGENTA_RED;
         base   = 9'd300;
      end else if (in_hue >= 9'd240) begin
         sec_in = SEC_BLUE_MAGENTA;
         base   = 9'd240;
      end else if (in_hue >= 9'd180) begin
         sec_in = SEC_CYAN_BLUE;
         base   = 9'd180;
      end else if (in_hue >= 9'd120) begin
         sec_in = SEC_GREEN_CYAN;
         base   = 9'd120;
      end else if (in_hue >= 9'd60) begin
         sec_in = SEC_YELLOW_GREEN;
         base   = 9'd60;
      end else begin
         sec_in = SEC_RED_YELLOW;
         base   = 9'd0;
      end
      f_in = FRAC_W'(in_hue - base);

      xp_in = COLOR_FULL - saturation;
      xq_in = FRAC_SCALE - (XQ_W'(saturation) * XQ_W'(f1_ff));
      xt_in = FRAC_SCALE - (XQ_W'(saturation) * XQ_W'(SECTOR_WIDTH - f1_ff));

      pn_in = PN_W'(brightness) * PN_W'(xp2_ff);
      qn_in = QN_W'(brightness) * QN_W'(xq2_ff);
      tn_in = QN_W'(brightness) * QN_W'(xt2_ff);

      p_prod = PP_W'(pn3_ff) * PP_W'(P_RECIP);
      q_prod = QP_W'(qn3_ff) * QP_W'(Q_RECIP);
      t_prod = QP_W'(tn3_ff) * QP_W'(Q_RECIP);
      p_in   = p_prod[P_SHIFT +: COLOR_W];
      q_in   = q_prod[Q_SHIFT +: COLOR_W];
      t_in   = t_prod[Q_SHIFT +: COLOR_W];

      case (sec4_ff)
         SEC_RED_YELLOW: begin
            red_in = brightness; green_in = t4_ff; blue_in = p4_ff;
         end
         SEC_YELLOW_GREEN: begin
            red_in = q4_ff; green_in = brightness; blue_in = p4_ff;
         end
         SEC_GREEN_CYAN: begin
            red_in = p4_ff; green_in = brightness; blue_in = t4_ff;
         end
         SEC_CYAN_BLUE: begin
            red_in = p4_ff; green_in = q4_ff; blue_in = brightness;
         end
         SEC_BLUE_MAGENTA: begin
            red_in = t4_ff; green_in = p4_ff; blue_in = brightness;
         end
         default: begin
            red_in = brightness; green_in = p4_ff; blue_in = q4_ff;
         end
      endcase
      if (saturation == '0) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (ready[0] && in_valid) begin
         hue1_ff <= in_hue;
         sec1_ff <= sec_in;
         f1_ff   <= f_in;
      end
      if (ready[1] && valid_ff[0]) begin
         hue2_ff <= hue1_ff;
         sec2_ff <= sec1_ff;
         xp2_ff  <= xp_in;
         xq2_ff  <= xq_in;
         xt2_ff  <= xt_in;
      end
      if (ready[2] && valid_ff[1]) begin
         hue3_ff <= hue2_ff;
         sec3_ff <= sec2_ff;
         pn3_ff  <= pn_in;
         qn3_ff  <= qn_in;
         tn3_ff  <= tn_in;
      end
      if (ready[3] && valid_ff[2]) begin
         hue4_ff <= hue3_ff;
         sec4_ff <= sec3_ff;
         p4_ff   <= p_in;
         q4_ff   <= q_in;
         t4_ff   <= t_in;
      end
      if (ready[4] && valid_ff[3]) begin
         hue5_ff   <= hue4_ff;
         red5_ff   <= red_in;
         green5_ff <= green_in;
         blue5_ff  <= blue_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_hue   = hue5_ff[COLOR_W-1:0];
   assign out_red   = red5_ff;
   assign out_green = green5_ff;
   assign out_blue  = blue5_ff;

endmodule

### sv/value_to_rainbow_rgb.sv
// Maps one signed sample per request to a rainbow color: the sample is clamped into the
// window [range_min, range_max], scaled to a hue of 0 to HUE_SPAN and turned into 8-bit
// red, green and blue by the six-sector HSV rule with the programmed saturation and
// brightness (zero saturation gives black). A new request is taken in every cycle while
// responses are not stalled, and each one gives exactly one response, in order, after
// passing the clamping and scaling registers, one restoring divider cell per hue bit
// and the color stages. Every stage holds its item while the next is full, so requests
// keep flowing into empty stages while a response waits. The user must write registers
// through the csr port only while no request is in flight; the block does not enforce
// this. An empty or inverted window gives a hue of zero.
module value_to_rainbow_rgb
   import vrgb_pkg::*;
#(
   parameter int SAMPLE_BITS = 32,
   parameter int HUE_SPAN    = 240
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [COLOR_W-1:0]            rsp_hue,
   output logic [COLOR_W-1:0]            rsp_red,
   output logic [COLOR_W-1:0]            rsp_green,
   output logic [COLOR_W-1:0]            rsp_blue,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]              csr_data
);

   localparam int QB = $clog2(HUE_SPAN + 1);
   localparam int NW = CFG_W + QB;

   logic signed [CFG_W-1:0] range_min_ff, range_max_ff;
   logic [COLOR_W-1:0]      saturation_ff, brightness_ff;

   logic                    front_ready;
   logic [QB:0]             chain_valid, chain_ready;
   logic [NW-1:0]           chain_rem [QB+1];
   logic [CFG_W-1:0]        chain_den [QB+1];
   logic [QB-1:0]           chain_quo [QB+1];
   logic                    color_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff  <= RANGE_MIN_RST;
         range_max_ff  <= RANGE_MAX_RST;
         saturation_ff <= SATURATION_RST;
         brightness_ff <= BRIGHTNESS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RANGE_MIN:  range_min_ff  <= csr_data;
            CSR_RANGE_MAX:  range_max_ff  <= csr_data;
            CSR_SATURATION: saturation_ff <= csr_data[COLOR_W-1:0];
            CSR_BRIGHTNESS: brightness_ff <= csr_data[COLOR_W-1:0];
         endcase
      end
   end

   assign req_stall = !front_ready;

   vrgb_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .HUE_SPAN    (HUE_SPAN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_sample (req_sample),
      .range_min (range_min_ff),
      .range_max (range_max_ff),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_num   (chain_rem[0]),
      .out_den   (chain_den[0])
   );

   assign chain_quo[0] = '0;

   for (genvar i = 0; i < QB; i++) begin : g_div
      vrgb_div_cell #(
         .NW  (NW),
         .QB  (QB),
         .BIT (QB - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_rem    (chain_rem[i]),
         .in_den    (chain_den[i]),
         .in_quo    (chain_quo[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_rem   (chain_rem[i+1]),
         .out_den   (chain_den[i+1]),
         .out_quo   (chain_quo[i+1])
      );
   end

   assign chain_ready[QB] = color_ready;

   vrgb_color u_color (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[QB]),
      .in_ready   (color_ready),
      .in_hue     (HUE_W'(chain_quo[QB])),
      .saturation (saturation_ff),
      .brightness (brightness_ff),
      .out_valid  (rsp_valid),
      .out_ready  (!rsp_stall),
      .out_hue    (rsp_hue),
      .out_red    (rsp_red),
      .out_green  (rsp_green),
      .out_blue   (rsp_blue)
   );

endmodule

### tb/testbench.sv
module testbench
   import vrgb_pkg::*;
();

   localparam int HUE_SPAN = 240;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 155;
   localparam longint SAMPLE_MIN = -64'sd2147483648;
   localparam longint SAMPLE_MAX = 64'sd2147483647;

   typedef struct packed {
      logic [COLOR_W-1:0] hue;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

   class rainbow_scoreboard;
      logic signed [CFG_W-1:0] range_min;
      logic signed [CFG_W-1:0] range_max;
      logic [COLOR_W-1:0] saturation;
      logic [COLOR_W-1:0] brightness;
      color_type expected_colors[$];
      int error_count;
      int samples_seen;

      function new();
         range_min = RANGE_MIN_RST;
         range_max = RANGE_MAX_RST;
         saturation = SATURATION_RST;
         brightness = BRIGHTNESS_RST;
         error_count = 0;
         samples_seen = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CFG_W-1:0] data);
         case (index)
            CSR_RANGE_MIN: range_min = data;
            CSR_RANGE_MAX: range_max = data;
            CSR_SATURATION: saturation = data[COLOR_W-1:0];
            CSR_BRIGHTNESS: brightness = data[COLOR_W-1:0];
            default: ;
         endcase
      endfunction

      function color_type predict_color(logic signed [31:0] sample);
         longint lo, hi, c;
         int h, f, s, v, p, q, t;
         color_type col;
         lo = range_min;
         hi = range_max;
         h = 0;
         if (hi > lo) begin
            c = sample;
            if (c < lo) c = lo;
            if (c > hi) c = hi;
            h = int'((c - lo) * HUE_SPAN / (hi - lo));
         end
         s = saturation;
         v = brightness;
         col = '0;
         col.hue = h[COLOR_W-1:0];
         if (s != 0) begin
            f = h % 60;
            p = v * (255 - s) / 255;
            q = v * (15300 - s * f) / 15300;
            t = v * (15300 - s * (60 - f)) / 15300;
            case (sector_type'(3'(h / 60)))
               SEC_RED_YELLOW: col[23:0] = {8'(v), 8'(t), 8'(p)};
               SEC_YELLOW_GREEN: col[23:0] = {8'(q), 8'(v), 8'(p)};
               SEC_GREEN_CYAN: col[23:0] = {8'(p), 8'(v), 8'(t)};
               SEC_CYAN_BLUE: col[23:0] = {8'(p), 8'(q), 8'(v)};
               SEC_BLUE_MAGENTA: col[23:0] = {8'(t), 8'(p), 8'(v)};
               default: col[23:0] = {8'(v), 8'(p), 8'(q)};
            endcase
         end
         return col;
      endfunction

      function void note_sample(logic signed [31:0] sample);
         expected_colors = {expected_colors, predict_color(sample)};
         samples_seen++;
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction

      task report_error(string msg);
         error_count++;
         if (error_count <= 50) $display("ERROR at %0t: %s", $time, msg);
      endtask

      task check_color(color_type got);
         color_type want;
         if (expected_colors.size() == 0) begin
            report_error($sformatf("response %h with no request outstanding", got));
         end else begin
            want = expected_colors.pop_front();
            if (got.hue !== want.hue)
               report_error($sformatf("hue %0d, expected %0d", got.hue, want.hue));
            if (got.red !== want.red)
               report_error($sformatf("red %0d, expected %0d", got.red, want.red));
            if (got.green !== want.green)
               report_error($sformatf("green %0d, expected %0d", got.green, want.green));
            if (got.blue !== want.blue)
               report_error($sformatf("blue %0d, expected %0d", got.blue, want.blue));
         end
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [COLOR_W-1:0] rsp_hue, rsp_red, rsp_green, rsp_blue;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   rainbow_scoreboard sb = new();
   bit steady = 1'b0;
   int unsigned hold_off = 0;
   int settings_count = 0;
   int input_stall_cycles = 0;

   value_to_rainbow_rgb #(
      .SAMPLE_BITS(32),
      .HUE_SPAN(HUE_SPAN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hue(rsp_hue),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_register(csr_index, csr_data);
         if (req_valid && !req_stall) sb.note_sample(req_sample);
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) sb.check_color({rsp_hue, rsp_red, rsp_green, rsp_blue});
      end
   end

   initial begin : result_sink
      int unsigned held;
      forever begin
         @(posedge clock);
         if (hold_off != 0) begin
            held = hold_off;
            hold_off = 0;
            rsp_stall <= 1'b1;
            repeat (held) @(posedge clock);
         end else begin
            rsp_stall <= !steady && ($urandom_range(0, 99) < 9);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("** value_to_rainbow_rgb: FAILED **");
      $finish;
   end

   task send_sample(input logic signed [31:0] sample);
      while (!steady && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (req_stall);
   endtask

   task wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task program_settings(input logic [31:0] lo, input logic [31:0] hi,
                         input logic [7:0] s, input logic [7:0] v);
      logic [CFG_W-1:0] values [4];
      logic [CSR_INDEX_W-1:0] indexes [4];
      int i;
      values = '{lo, hi, 32'(s), 32'(v)};
      indexes = '{CSR_RANGE_MIN, CSR_RANGE_MAX, CSR_SATURATION, CSR_BRIGHTNESS};
      wait_until_drained();
      for (i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= indexes[i];
         csr_data <= values[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   function logic signed [31:0] pick_sample(longint lo, longint hi);
      int unsigned mode;
      longint c;
      mode = $urandom_range(0, 99);
      if (hi < lo || mode < 20) return $urandom;
      if (mode < 30) begin
         case ($urandom_range(0, 3))
            0: c = lo;
            1: c = hi;
            2: c = lo - 1;
            default: c = hi + 1;
         endcase
         if (c < SAMPLE_MIN) c = SAMPLE_MIN;
         if (c > SAMPLE_MAX) c = SAMPLE_MAX;
      end else begin
         c = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
      end
      return 32'(c);
   endfunction

   function logic [7:0] pick_fraction();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      longint lo, hi;
      int phase, n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Power-up window, with samples at both ends of the 32-bit range.
      send_sample(32'sh8000_0000);
      send_sample(32'sh7fff_ffff);
      send_sample(-32'sd300000);
      send_sample(-32'sd150000);
      send_sample(-32'sd225000);

      // A window of exactly the hue span walks through the sectors from red-yellow to blue-magenta.
      program_settings(32'd0, 32'd240, 8'd255, 8'd255);
      send_sample(32'sd0);
      send_sample(32'sd59);
      send_sample(32'sd60);
      send_sample(32'sd120);
      send_sample(32'sd180);
      send_sample(32'sd239);
      send_sample(32'sd240);
      send_sample(32'sd300);

      // Widest window with zero saturation gives black.
      program_settings(32'h8000_0000, 32'h7fff_ffff, 8'd0, 8'd255);
      send_sample(32'sh8000_0000);
      send_sample(32'sd0);
      send_sample(32'sh7fff_ffff);

      // Empty and inverted windows both pin the hue to zero.
      program_settings(32'd5, 32'd5, 8'd128, 8'd77);
      send_sample(32'sd5);
      send_sample(-32'sd7);
      program_settings(32'd1000, -32'sd1000, 8'd1, 8'd0);
      send_sample(32'sd0);
      send_sample(32'sh5555_5555);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase == 0 ? 4 : $urandom_range(0, 4))
            0: begin
               lo = int'($urandom);
               hi = int'($urandom);
            end
            1: begin
               lo = int'($urandom);
               hi = lo + longint'($urandom_range(1, 2000));
            end
            2: begin
               lo = longint'($urandom_range(0, 2000000)) - 1000000;
               hi = lo + longint'($urandom_range(1, 480));
            end
            3: begin
               lo = int'($urandom);
               hi = lo;
            end
            default: begin
               lo = SAMPLE_MIN + longint'($urandom_range(0, 1000));
               hi = SAMPLE_MAX - longint'($urandom_range(0, 1000));
            end
         endcase
         if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
         program_settings(32'(lo), 32'(hi), pick_fraction(), pick_fraction());
         steady = (phase == 3);
         if (phase == 5) hold_off = 300;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_sample(pick_sample(lo, hi));
         end
      end

      wait_until_drained();
      repeat (40) @(posedge clock);
      if (sb.pending() != 0) sb.report_error("requests left without a response");
      $display("Covered %0d samples over %0d register settings, including extreme,",
               sb.samples_seen, settings_count + 1);
      $display("empty, inverted and zero-saturation cases; input stalled %0d cycles.",
               input_stall_cycles);
      if (sb.error_count == 0) begin
         $display("** value_to_rainbow_rgb: PASSED **");
      end else begin
         $display("** value_to_rainbow_rgb: FAILED **");
      end
      $finish;
   end

endmodule
